FILE: hdl/next_fit_heap_allocator_defines.svh
// ----------------------------------------------------------------------------
// next_fit_heap_allocator_defines.svh
// Assertion macros for the allocator checker.
// ----------------------------------------------------------------------------
`ifndef NEXT_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define NEXT_FIT_HEAP_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define NFHA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define NFHA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/nfha_pkg.sv
// ----------------------------------------------------------------------------
// nfha_pkg
// Shared constants, header record, datapath commands and status.
// ----------------------------------------------------------------------------
package nfha_pkg;

	localparam int HEAP_UNITS = 4096;
	localparam int UNIT_BYTES = 32;
	localparam int IDX_W      = $clog2(HEAP_UNITS);
	localparam int SIZE_W     = IDX_W + 1;
	localparam int BYTES_W    = 18;
	localparam int UNIT_SHIFT = $clog2(UNIT_BYTES);
	localparam int NEED_W     = BYTES_W - UNIT_SHIFT + 1;
	localparam int WALK_LIMIT = 2 * HEAP_UNITS + 4;
	localparam int STEP_W     = $clog2(WALK_LIMIT + 2) + 1;
	localparam int GROW_W     = 12;
	localparam int GROW_RESET = 128;

	typedef struct packed {
		logic [IDX_W-1:0]  prev;
		logic [IDX_W-1:0]  next;
		logic [SIZE_W-1:0] size;
		logic              free;
	} hdr_t;

	typedef enum logic [4:0] {
		OP_NOP,
		OP_CLEAR,
		OP_LOAD,
		OP_A_RD_ROVER,
		OP_A_TAKE_NEXT,
		OP_A_RD_P,
		OP_A_EXACT,
		OP_A_SPLIT1,
		OP_A_SPLIT2,
		OP_A_SPLIT3,
		OP_A_ADV,
		OP_FAIL,
		OP_G_START,
		OP_G_RD,
		OP_G_ADV,
		OP_G_LINK1,
		OP_G_LINK2,
		OP_G_LINK3,
		OP_R_MARK,
		OP_R_RD_BP,
		OP_R_RD_N,
		OP_R_MERGE_N1,
		OP_R_MERGE_N2,
		OP_R_RD_PV,
		OP_R_MERGE_P1,
		OP_R_MERGE_P2,
		OP_R_ROVER,
		OP_F_RD_BP,
		OP_F_RD_PV,
		OP_OUT
	} dp_op_t;

	typedef struct packed {
		logic clr_last;
		logic cmd_free;
		logic out_full;
		logic steps_over;
		logic fit;
		logic exact;
		logic at_rover;
		logic grow_ok;
		logic walk_more;
		logic merge_n;
		logic merge_p;
		logic free_skip;
		logic hdr_bad;
		logic link_bad;
	} dp_status_t;

endpackage

FILE: hdl/next_fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// next_fit_heap_allocator
// Next-fit heap allocator with coalescing over a 4096-unit header store.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------------------
//  in       | in_valid / in_stall    | cmd, request_bytes, payload_unit
//  out      | out_valid / out_stall  | payload_unit_out, status
//  cfg      | cfg_valid / cfg_ready  | grow_units
//
//  After reset the header store is zeroed, one entry a cycle, with in_stall
//  high. Config writes are taken throughout.
//  Each command takes a data-dependent time, set by the single port header
//  store: an allocate reads each block it visits, a split adds writes, a heap
//  grow walks blocks, then links, releases and restarts the allocate. A free
//  checks the block and, if valid, releases it. The result register is loaded
//  last; the next item is taken while that result waits on out_stall.
// ----------------------------------------------------------------------------
module next_fit_heap_allocator
	import nfha_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               cmd,
	input  logic [BYTES_W-1:0] request_bytes,
	input  logic [IDX_W-1:0]   payload_unit,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [IDX_W-1:0]   payload_unit_out,
	output logic               status,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [GROW_W-1:0]  grow_units
);

	// sequencer commands and datapath flags
	dp_op_t     op;
	dp_status_t st;

	// walk control: alloc search, grow, release and free checks
	nfha_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.op       (op)
	);

	// header store, pointers and the result register
	nfha_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.op               (op),
		.st               (st),
		.cmd              (cmd),
		.request_bytes    (request_bytes),
		.payload_unit     (payload_unit),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.payload_unit_out (payload_unit_out),
		.status           (status),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.grow_units       (grow_units)
	);

endmodule

FILE: hdl/nfha_ctrl.sv
// ----------------------------------------------------------------------------
// nfha_ctrl
// Sequencer: steps the datapath through alloc, grow, release and free.
// ----------------------------------------------------------------------------
module nfha_ctrl
	import nfha_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  dp_status_t st,
	output dp_op_t     op
);

	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_A_RD_ROVER,
		S_A_TAKE_NEXT,
		S_A_RD_P,
		S_A_EVAL,
		S_A_SPLIT2,
		S_A_SPLIT3,
		S_G_RD,
		S_G_EVAL,
		S_G_LINK2,
		S_G_LINK3,
		S_R_MARK,
		S_R_RD_BP,
		S_R_RD_N,
		S_R_EVAL_N,
		S_R_MERGE_N2,
		S_R_RD_BP2,
		S_R_RD_PV,
		S_R_EVAL_P,
		S_R_MERGE_P2,
		S_R_RD_BP3,
		S_R_ROVER,
		S_F_CHECK,
		S_F_EVAL,
		S_F_LINK,
		S_DONE
	} state_t;

	state_t state_q, state_d;
	logic   from_grow_q, from_grow_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d     = state_q;
		from_grow_d = from_grow_q;
		op          = OP_NOP;
		unique case (state_q)
			S_CLEAR: begin
				op = OP_CLEAR;
				if (st.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					op          = OP_LOAD;
					from_grow_d = 1'b0;
					state_d     = st.cmd_free ? S_F_CHECK : S_A_RD_ROVER;
				end
			end
			S_A_RD_ROVER: begin
				op      = OP_A_RD_ROVER;
				state_d = S_A_TAKE_NEXT;
			end
			S_A_TAKE_NEXT: begin
				op      = OP_A_TAKE_NEXT;
				state_d = S_A_RD_P;
			end
			S_A_RD_P: begin
				if (st.steps_over) begin
					op      = OP_FAIL;
					state_d = S_DONE;
				end else begin
					op      = OP_A_RD_P;
					state_d = S_A_EVAL;
				end
			end
			S_A_EVAL: begin
				if (st.fit && st.exact) begin
					op      = OP_A_EXACT;
					state_d = S_DONE;
				end else if (st.fit) begin
					op      = OP_A_SPLIT1;
					state_d = S_A_SPLIT2;
				end else if (st.at_rover) begin
					if (st.grow_ok) begin
						op      = OP_G_START;
						state_d = S_G_RD;
					end else begin
						op      = OP_FAIL;
						state_d = S_DONE;
					end
				end else begin
					op      = OP_A_ADV;
					state_d = S_A_RD_P;
				end
			end
			S_A_SPLIT2: begin
				op      = OP_A_SPLIT2;
				state_d = S_A_SPLIT3;
			end
			S_A_SPLIT3: begin
				op      = OP_A_SPLIT3;
				state_d = S_DONE;
			end
			S_G_RD: begin
				op      = OP_G_RD;
				state_d = S_G_EVAL;
			end
			S_G_EVAL: begin
				if (st.walk_more) begin
					op      = OP_G_ADV;
					state_d = S_G_RD;
				end else begin
					op      = OP_G_LINK1;
					state_d = S_G_LINK2;
				end
			end
			S_G_LINK2: begin
				op      = OP_G_LINK2;
				state_d = S_G_LINK3;
			end
			S_G_LINK3: begin
				op          = OP_G_LINK3;
				from_grow_d = 1'b1;
				state_d     = S_R_MARK;
			end
			S_R_MARK: begin
				op      = OP_R_MARK;
				state_d = S_R_RD_BP;
			end
			S_R_RD_BP: begin
				op      = OP_R_RD_BP;
				state_d = S_R_RD_N;
			end
			S_R_RD_N: begin
				op      = OP_R_RD_N;
				state_d = S_R_EVAL_N;
			end
			S_R_EVAL_N: begin
				if (st.merge_n) begin
					op      = OP_R_MERGE_N1;
					state_d = S_R_MERGE_N2;
				end else begin
					state_d = S_R_RD_BP2;
				end
			end
			S_R_MERGE_N2: begin
				op      = OP_R_MERGE_N2;
				state_d = S_R_RD_BP2;
			end
			S_R_RD_BP2: begin
				op      = OP_R_RD_BP;
				state_d = S_R_RD_PV;
			end
			S_R_RD_PV: begin
				op      = OP_R_RD_PV;
				state_d = S_R_EVAL_P;
			end
			S_R_EVAL_P: begin
				if (st.merge_p) begin
					op      = OP_R_MERGE_P1;
					state_d = S_R_MERGE_P2;
				end else begin
					state_d = S_R_RD_BP3;
				end
			end
			S_R_MERGE_P2: begin
				op      = OP_R_MERGE_P2;
				state_d = S_R_RD_BP3;
			end
			S_R_RD_BP3: begin
				op      = OP_R_RD_BP;
				state_d = S_R_ROVER;
			end
			S_R_ROVER: begin
				op      = OP_R_ROVER;
				state_d = from_grow_q ? S_A_RD_ROVER : S_DONE;
			end
			S_F_CHECK: begin
				if (st.free_skip) begin
					state_d = S_DONE;
				end else begin
					op      = OP_F_RD_BP;
					state_d = S_F_EVAL;
				end
			end
			S_F_EVAL: begin
				if (st.hdr_bad) begin
					state_d = S_DONE;
				end else begin
					op      = OP_F_RD_PV;
					state_d = S_F_LINK;
				end
			end
			S_F_LINK: begin
				state_d = st.link_bad ? S_DONE : S_R_MARK;
			end
			S_DONE: begin
				if (!st.out_full) begin
					op      = OP_OUT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			from_grow_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			from_grow_q <= from_grow_d;
		end
	end

endmodule

FILE: hdl/nfha_dp.sv
// ----------------------------------------------------------------------------
// nfha_dp
// Header store, list pointers, heap top, rover and result register.
// ----------------------------------------------------------------------------
module nfha_dp
	import nfha_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  dp_op_t             op,
	output dp_status_t         st,
	input  logic               cmd,
	input  logic [BYTES_W-1:0] request_bytes,
	input  logic [IDX_W-1:0]   payload_unit,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [IDX_W-1:0]   payload_unit_out,
	output logic               status,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [GROW_W-1:0]  grow_units
);

	localparam logic [SIZE_W-1:0] HU_SIZE = SIZE_W'(HEAP_UNITS);

	// header store, one array per field so fields write independently
	logic [IDX_W-1:0]  mem_prev [HEAP_UNITS];
	logic [IDX_W-1:0]  mem_next [HEAP_UNITS];
	logic [SIZE_W-1:0] mem_size [HEAP_UNITS];
	logic              mem_free [HEAP_UNITS];
	hdr_t              rd_q;

	logic [SIZE_W-1:0] heap_top_q;
	logic [IDX_W-1:0]  rover_q, p_q, prv_q, bp_q, n_q, pv_q, pu_q, res_q, clr_q;
	logic [IDX_W-1:0]  out_unit_q;
	logic [GROW_W-1:0] grow_q;
	logic [NEED_W-1:0] need_q, nu;
	logic [SIZE_W-1:0] sz_q, room;
	logic [STEP_W-1:0] steps_q;
	logic [SIZE_W-1:0] k_q;
	logic              fail_q, out_valid_q, out_status_q;

	logic              rd_en, we_prev, we_next, we_size, we_free;
	logic [IDX_W-1:0]  rd_addr, wr_addr, wr_prev, wr_next;
	logic [SIZE_W-1:0] wr_size;
	logic              wr_free;
	logic [IDX_W-1:0]  diff, newp;
	logic [NEED_W-1:0] need_in;
	logic [BYTES_W:0]  bytes_up;

	function automatic logic [SIZE_W-1:0] sat_sum(logic [SIZE_W-1:0] a, logic [SIZE_W-1:0] b);
		logic [SIZE_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return (s > {1'b0, HU_SIZE}) ? HU_SIZE : s[SIZE_W-1:0];
	endfunction

	assign bytes_up = {1'b0, request_bytes} + (BYTES_W+1)'(UNIT_BYTES - 1);
	assign need_in  = NEED_W'(bytes_up >> UNIT_SHIFT) + NEED_W'(1);
	assign nu       = (need_q < NEED_W'(grow_q)) ? NEED_W'(grow_q) : need_q;
	assign room     = HU_SIZE - heap_top_q;
	assign diff     = IDX_W'(rd_q.size - need_q[SIZE_W-1:0]);
	assign newp     = p_q + diff;

	// status toward the sequencer
	always_comb begin
		st.clr_last   = (clr_q == '1);
		st.cmd_free   = cmd;
		st.out_full   = out_valid_q && out_stall;
		st.steps_over = (steps_q > STEP_W'(WALK_LIMIT));
		st.fit        = rd_q.free && (NEED_W'(rd_q.size) >= need_q);
		st.exact      = (NEED_W'(rd_q.size) == need_q);
		st.at_rover   = (p_q == rover_q);
		st.grow_ok    = (nu <= NEED_W'(room));
		st.walk_more  = (k_q < HU_SIZE) && (rd_q.next > p_q);
		st.merge_n    = rd_q.free &&
			((SIZE_W+1)'(bp_q) + (SIZE_W+1)'(sz_q) == (SIZE_W+1)'(n_q));
		st.merge_p    = rd_q.free &&
			((SIZE_W+1)'(pv_q) + (SIZE_W+1)'(rd_q.size) == (SIZE_W+1)'(bp_q));
		st.free_skip  = (pu_q < IDX_W'(2)) || (SIZE_W'(bp_q) >= heap_top_q);
		st.hdr_bad    = (rd_q.size == '0) || rd_q.free;
		st.link_bad   = (rd_q.next != bp_q);
	end

	// store port decode
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = bp_q;
		we_prev = 1'b0;
		we_next = 1'b0;
		we_size = 1'b0;
		we_free = 1'b0;
		wr_addr = bp_q;
		wr_prev = '0;
		wr_next = '0;
		wr_size = '0;
		wr_free = 1'b0;
		case (op)
			OP_CLEAR: begin
				wr_addr = clr_q;
				we_prev = 1'b1;
				we_next = 1'b1;
				we_size = 1'b1;
				we_free = 1'b1;
			end
			OP_A_RD_ROVER: begin
				rd_en   = 1'b1;
				rd_addr = rover_q;
			end
			OP_A_RD_P, OP_G_RD: begin
				rd_en   = 1'b1;
				rd_addr = p_q;
			end
			OP_R_RD_BP, OP_F_RD_BP: rd_en = 1'b1;
			OP_R_RD_N: begin
				rd_en   = 1'b1;
				rd_addr = rd_q.next;
			end
			OP_R_RD_PV, OP_F_RD_PV: begin
				rd_en   = 1'b1;
				rd_addr = rd_q.prev;
			end
			OP_A_EXACT: begin
				wr_addr = p_q;
				we_free = 1'b1;
			end
			OP_A_SPLIT1: begin
				wr_addr = p_q;
				we_size = 1'b1;
				we_next = 1'b1;
				wr_size = SIZE_W'(diff);
				wr_next = newp;
			end
			OP_A_SPLIT2: begin
				we_size = 1'b1;
				we_prev = 1'b1;
				we_next = 1'b1;
				we_free = 1'b1;
				wr_size = (need_q > NEED_W'(HU_SIZE)) ? HU_SIZE : need_q[SIZE_W-1:0];
				wr_prev = p_q;
				wr_next = n_q;
			end
			OP_A_SPLIT3, OP_G_LINK3, OP_R_MERGE_N2, OP_R_MERGE_P2: begin
				wr_addr = n_q;
				we_prev = 1'b1;
				wr_prev = bp_q;
			end
			OP_G_START: begin
				wr_addr = heap_top_q[IDX_W-1:0];
				we_size = 1'b1;
				we_free = 1'b1;
				wr_size = nu[SIZE_W-1:0];
			end
			OP_G_LINK1: begin
				wr_addr = p_q;
				we_next = 1'b1;
				wr_next = bp_q;
			end
			OP_G_LINK2: begin
				we_prev = 1'b1;
				we_next = 1'b1;
				wr_prev = p_q;
				wr_next = n_q;
			end
			OP_R_MARK: begin
				we_free = 1'b1;
				wr_free = 1'b1;
			end
			OP_R_MERGE_N1: begin
				we_size = 1'b1;
				we_next = 1'b1;
				wr_size = sat_sum(sz_q, rd_q.size);
				wr_next = rd_q.next;
			end
			OP_R_MERGE_P1: begin
				wr_addr = pv_q;
				we_size = 1'b1;
				we_next = 1'b1;
				wr_size = sat_sum(rd_q.size, sz_q);
				wr_next = n_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we_prev) mem_prev[wr_addr] <= wr_prev;
		if (we_next) mem_next[wr_addr] <= wr_next;
		if (we_size) mem_size[wr_addr] <= wr_size;
		if (we_free) mem_free[wr_addr] <= wr_free;
		if (rd_en) begin
			rd_q <= '{prev: mem_prev[rd_addr], next: mem_next[rd_addr],
				size: mem_size[rd_addr], free: mem_free[rd_addr]};
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD: begin
				need_q  <= need_in;
				pu_q    <= payload_unit;
				bp_q    <= payload_unit - IDX_W'(1);
				steps_q <= '0;
				res_q   <= '0;
				fail_q  <= 1'b0;
			end
			OP_A_RD_ROVER: prv_q <= rover_q;
			OP_A_TAKE_NEXT: p_q <= rd_q.next;
			OP_A_ADV: begin
				prv_q   <= p_q;
				p_q     <= rd_q.next;
				steps_q <= steps_q + STEP_W'(1);
			end
			OP_A_EXACT: res_q <= p_q + IDX_W'(1);
			OP_A_SPLIT1: begin
				n_q  <= rd_q.next;
				bp_q <= newp;
			end
			OP_A_SPLIT3: res_q <= bp_q + IDX_W'(1);
			OP_FAIL: begin
				fail_q <= 1'b1;
				res_q  <= '0;
			end
			OP_G_START: begin
				bp_q <= heap_top_q[IDX_W-1:0];
				p_q  <= rover_q;
				k_q  <= '0;
			end
			OP_G_ADV: begin
				p_q <= rd_q.next;
				k_q <= k_q + SIZE_W'(1);
			end
			OP_G_LINK1: n_q <= rd_q.next;
			OP_R_RD_N: begin
				n_q  <= rd_q.next;
				sz_q <= rd_q.size;
			end
			OP_R_MERGE_N1: n_q <= rd_q.next;
			OP_R_RD_PV: begin
				pv_q <= rd_q.prev;
				sz_q <= rd_q.size;
				n_q  <= rd_q.next;
			end
			OP_R_MERGE_P1: bp_q <= pv_q;
			OP_R_ROVER: steps_q <= steps_q + STEP_W'(1);
			OP_OUT: begin
				out_unit_q   <= res_q;
				out_status_q <= fail_q;
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_top_q  <= SIZE_W'(1);
			rover_q     <= '0;
			grow_q      <= GROW_W'(GROW_RESET);
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) grow_q <= grow_units;
			if (op == OP_CLEAR) clr_q <= clr_q + IDX_W'(1);
			if (op == OP_G_START) heap_top_q <= heap_top_q + nu[SIZE_W-1:0];
			if (op == OP_A_EXACT || op == OP_A_SPLIT3) rover_q <= prv_q;
			if (op == OP_R_ROVER) rover_q <= rd_q.prev;
			if (op == OP_OUT) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	assign out_valid        = out_valid_q;
	assign payload_unit_out = out_unit_q;
	assign status           = out_status_q;
	assign cfg_ready        = 1'b1;

endmodule

FILE: hdl/nfha_checker.sv
// ----------------------------------------------------------------------------
// nfha_checker
// Port-level checks on the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "next_fit_heap_allocator_defines.svh"

module nfha_checker
	import nfha_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic [IDX_W-1:0]   payload_unit_out,
	input logic               status,
	input logic               cfg_valid,
	input logic               cfg_ready
);

	`NFHA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped under stall")
	`NFHA_ASSERT_NOW(a_oom_null, out_valid && status, payload_unit_out == '0, "failed alloc with unit")
	`NFHA_ASSERT_NEXT(a_one_at_time, in_valid && !in_stall, in_stall, "second item taken at once")
	`NFHA_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready, "config write refused")

endmodule

bind next_fit_heap_allocator nfha_checker u_nfha_checker (.*);
